// ===== hdl/srs_pkg.sv =====
// shared constants for the screen refresh sequencer
`timescale 1ns / 1ps
`default_nettype none
package srs_pkg;

	// default screen geometry
	localparam int LINES_DEFAULT       = 2;
	localparam int LINE_LENGTH_DEFAULT = 16;

	// sequencer phase codes
	localparam logic [1:0] PH_LINE  = 2'd0;
	localparam logic [1:0] PH_HOME  = 2'd1;
	localparam logic [1:0] PH_BREAK = 2'd2;

	// line break bytes
	localparam logic [7:0] BYTE_CR = 8'd13;
	localparam logic [7:0] BYTE_LF = 8'd10;

	// configuration register indexes
	localparam logic [1:0] CFG_HOME_FIRST  = 2'd0;
	localparam logic [1:0] CFG_HOME_SECOND = 2'd1;
	localparam logic [1:0] CFG_HOME_THIRD  = 2'd2;

	// configuration reset values
	localparam logic [7:0] HOME_FIRST_RST  = 8'd27;
	localparam logic [7:0] HOME_SECOND_RST = 8'd91;
	localparam logic [7:0] HOME_THIRD_RST  = 8'd72;

	localparam int HOME_LEN = 3;

endpackage
`default_nettype wire

// ===== hdl/uart_screen_refresh_sequencer_core.sv =====
// screen refresh sequencer: screen ram, byte stream sequencer and output stage
`timescale 1ns / 1ps
`default_nettype none
// usage
//   input channel (in_valid / in_stall): cmd 0 stores glyph at row/column of the
//   screen, cmd 1 is a transmitter-ready tick that yields exactly one tx_byte item
//   output channel (out_valid / out_stall): one tx_byte per tick, in tick order;
//   the stream is the three home bytes, then per line its characters, CR, LF
//   config channel (cfg_valid / cfg_ready): cfg_index selects a home byte,
//   cfg_ready is always high, write only while the block is idle
//   a tick's byte is registered in s1 (its screen ram read alongside), then moves
//   to the output register and is offered from there; one item per cycle
//   sustained while the output side does not stall, set by the single screen ram
//   read per tick and the two-entry result path (s1 + output reg)
//   writes out of screen range are dropped; a write is visible to the next tick
//   reset: home bytes return to 27 91 72, the stream restarts at the first home
//   byte, every screen cell reads zero (per-cell valid flops, no clearing pass)
//   receiver stall: the output register holds; one more result parks in s1,
//   after that in_stall rises until the output register is taken
module uart_screen_refresh_sequencer_core import srs_pkg::*; #(
	parameter int LINES       = LINES_DEFAULT,
	parameter int LINE_LENGTH = LINE_LENGTH_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input items
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       cmd,
	input  wire logic       row,
	input  wire logic [3:0] column,
	input  wire logic [7:0] glyph,
	// result items
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [7:0] tx_byte,
	// configuration writes
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int DEPTH = LINES * LINE_LENGTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int PWL   = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
	localparam int PW    = (PWL > 2) ? PWL : 2;

	// configuration registers
	logic [7:0] home_first_q, home_second_q, home_third_q;

	// sequencer state
	logic [1:0]    phase_q;
	logic [PW-1:0] pos_q;
	logic [LW-1:0] line_q;

	// per-cell written flags, an unwritten cell reads as zero
	logic [DEPTH-1:0] cell_vld_q;

	// result stage behind the ram read
	logic       s1_valid;
	logic       s1_from_mem;
	logic       s1_mem_ok;
	logic [7:0] s1_byte;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;

	// handshake
	logic out_take, out_free, s1_move, acc, tick, wr;

	// datapath
	logic          wr_in_range;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          rd_en;
	logic [7:0]    ram_rdata;
	logic [7:0]    seq_byte;
	logic          seq_from_mem;
	logic [1:0]    phase_d;
	logic [PW-1:0] pos_d;
	logic [LW-1:0] line_d;
	logic [7:0]    s1_result;

	assign cfg_ready = 1'b1;

	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || out_take;
	assign s1_move  = s1_valid && out_free;
	assign in_stall = s1_valid && !out_free;
	assign acc      = in_valid && !in_stall;
	assign tick     = acc && cmd;
	assign wr       = acc && !cmd;

	assign out_valid = out_valid_q;
	assign tx_byte   = out_byte_q;

	// screen addressing
	assign wr_in_range = (32'(row) < LINES) && (32'(column) < LINE_LENGTH);
	assign wr_addr     = AW'(32'(row) * LINE_LENGTH + 32'(column));
	assign rd_addr     = AW'(32'(line_q) * LINE_LENGTH + 32'(pos_q));

	// next byte of the stream and sequencer advance
	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		line_d       = line_q;
		seq_byte     = '0;
		seq_from_mem = 1'b0;
		unique case (phase_q)
			PH_LINE: begin
				seq_from_mem = 1'b1;
				if (pos_q >= PW'(LINE_LENGTH - 1)) begin
					phase_d = PH_BREAK;
					pos_d   = '0;
				end else begin
					pos_d = pos_q + PW'(1);
				end
			end
			PH_BREAK: begin
				if (pos_q >= PW'(1)) begin
					seq_byte = BYTE_LF;
					// last line wraps back to the home sequence
					if (line_q >= LW'(LINES - 1)) begin
						phase_d = PH_HOME;
						line_d  = '0;
					end else begin
						phase_d = PH_LINE;
						line_d  = line_q + LW'(1);
					end
					pos_d = '0;
				end else begin
					seq_byte = BYTE_CR;
					pos_d    = PW'(1);
				end
			end
			default: begin
				// home sequence, the unused phase code behaves the same
				if (pos_q == PW'(0)) begin
					seq_byte = home_first_q;
				end else if (pos_q == PW'(1)) begin
					seq_byte = home_second_q;
				end else begin
					seq_byte = home_third_q;
				end
				if (pos_q >= PW'(HOME_LEN - 1)) begin
					phase_d = PH_LINE;
					pos_d   = '0;
				end else begin
					phase_d = PH_HOME;
					pos_d   = pos_q + PW'(1);
				end
			end
		endcase
	end

	assign rd_en = tick && seq_from_mem;

	srs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_screen_ram (
		.clk  (clk),
		.we   (wr && wr_in_range),
		.waddr(wr_addr),
		.wdata(glyph),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_first_q  <= HOME_FIRST_RST;
			home_second_q <= HOME_SECOND_RST;
			home_third_q  <= HOME_THIRD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HOME_FIRST:  home_first_q  <= cfg_data;
				CFG_HOME_SECOND: home_second_q <= cfg_data;
				CFG_HOME_THIRD:  home_third_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and cell flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HOME;
			pos_q      <= '0;
			line_q     <= '0;
			cell_vld_q <= '0;
		end else begin
			if (tick) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				line_q  <= line_d;
			end
			if (wr && wr_in_range) begin
				cell_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick) begin
				s1_valid <= 1'b1;
			end else if (s1_move) begin
				s1_valid <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ram data holds while s1 waits since no read is issued then
	assign s1_result = s1_from_mem ? (s1_mem_ok ? ram_rdata : 8'd0) : s1_byte;

	always_ff @(posedge clk) begin
		if (tick) begin
			s1_from_mem <= seq_from_mem;
			s1_mem_ok   <= cell_vld_q[rd_addr];
			s1_byte     <= seq_byte;
		end
		if (s1_move) begin
			out_byte_q <= s1_result;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/srs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module srs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/srs_checker.sv =====
// port-level checker for the screen refresh sequencer and its bind
`timescale 1ns / 1ps
`default_nettype none
module srs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       cmd,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] tx_byte
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte))
		else $error("stalled tx_byte changed");

	// input back-pressure only while a result waits at a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without output back-pressure");

	// a tick taken with an empty output shows a result after passing s1 and the output register
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd && !out_valid |-> ##2 out_valid)
		else $error("tick result missing");

	// nothing offered during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("out_valid during reset");

endmodule

bind uart_screen_refresh_sequencer_core srs_checker u_srs_checker (.*);
`default_nettype wire
